// ===== hdl/biquad_pkg.sv =====
package biquad_pkg;

    localparam int DATA_W  = 16;
    localparam int COEF_W  = 16;
    localparam int ACC_W   = 50;
    localparam int SPLIT_W = 16;
    localparam int FF_W    = 2 * COEF_W + 1;
    localparam int OPA_W   = DATA_W + 1;
    localparam int PROD_W  = OPA_W + COEF_W;
    localparam int IDX_W   = 3;
    localparam int STEP_W  = 3;

    localparam int COEF_FRAC_BITS_DEFAULT = 14;

    localparam logic [IDX_W-1:0] REG_B0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_A1   = 3'd3;
    localparam logic [IDX_W-1:0] REG_A2   = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAIN = 3'd5;

    localparam logic signed [COEF_W-1:0] B0_RESET   = 16'sd16384;
    localparam logic signed [COEF_W-1:0] GAIN_RESET = 16'sd16384;

    localparam logic [STEP_W-1:0] OP_B0      = 3'd0;
    localparam logic [STEP_W-1:0] OP_B1      = 3'd1;
    localparam logic [STEP_W-1:0] OP_B2      = 3'd2;
    localparam logic [STEP_W-1:0] OP_A1      = 3'd3;
    localparam logic [STEP_W-1:0] OP_A2      = 3'd4;
    localparam logic [STEP_W-1:0] OP_GAIN_LO = 3'd5;
    localparam logic [STEP_W-1:0] OP_GAIN_HI = 3'd6;
    localparam logic [STEP_W-1:0] OP_LAST    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MAC    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

// ===== hdl/biquad_iir_section.sv =====
// Second-order direct-form-I IIR section, one signed 16-bit sample per transfer.
// Input channel: sample with in_valid; a transfer happens when in_stall is low.
// Output channel: filtered and saturated with out_valid; out_stall holds them.
// Coefficients and gain are written through cfg_write, cfg_index and cfg_data;
// the user must do so only while idle, unenforced; unused indexes are ignored.
// One 17 x 16 bit multiplier is shared over seven products per sample: three
// feedforward taps, two feedback taps and the gain applied in two halves.
// Each sample steps through the seven products in ST_MAC, then waits in
// ST_FINISH until the output register is free; the next sample is taken the
// cycle after the result is loaded.
// The result sits in an output register, so a new sample may be taken while it
// waits; if the receiver still stalls when the next result is ready, the
// section holds that result and keeps in_stall high until the register frees.
// Reset clears both histories, sets b0 and the gain to 1.0 and the other
// coefficients to zero, and leaves the output channel empty.
module biquad_iir_section #(
    parameter int COEF_FRAC_BITS = biquad_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [biquad_pkg::IDX_W-1:0]            cfg_index,
    input  logic [biquad_pkg::COEF_W-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [biquad_pkg::DATA_W-1:0]    sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [biquad_pkg::DATA_W-1:0]    filtered,
    output logic                                    saturated
);

    localparam int ACC_W = biquad_pkg::ACC_W;
    localparam int SHIFT = 2 * COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SHIFT - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX      = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN      = ACC_W'(-32768);

    biquad_pkg::state_t state_reg, state_next;
    logic [biquad_pkg::STEP_W-1:0] step_reg, step_next;
    logic [biquad_pkg::STEP_W-1:0] prev_op;

    logic signed [biquad_pkg::COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, gain_reg;
    logic signed [biquad_pkg::DATA_W-1:0] x_reg, x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [biquad_pkg::OPA_W-1:0]  mul_a;
    logic signed [biquad_pkg::COEF_W-1:0] mul_b;
    logic signed [biquad_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [biquad_pkg::FF_W-1:0]   ff_reg, ff_next;
    logic signed [ACC_W-1:0]              acc_reg, acc_next;
    logic signed [ACC_W-1:0]              prod_ext;
    logic signed [ACC_W-1:0]              y_wide;
    logic signed [biquad_pkg::DATA_W-1:0] y_sat;
    logic                                 y_clip;

    logic                                 out_valid_reg, out_valid_next;
    logic signed [biquad_pkg::DATA_W-1:0] filtered_reg;
    logic                                 saturated_reg;
    logic                                 in_take;
    logic                                 out_load;

    assign in_stall  = (state_reg != biquad_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_load  = (state_reg == biquad_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;
    assign prev_op   = step_reg - biquad_pkg::STEP_W'(1);
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            biquad_pkg::OP_B0:
            begin
                mul_a = biquad_pkg::OPA_W'(x_reg);
                mul_b = b0_reg;
            end
            biquad_pkg::OP_B1:
            begin
                mul_a = biquad_pkg::OPA_W'(x1_reg);
                mul_b = b1_reg;
            end
            biquad_pkg::OP_B2:
            begin
                mul_a = biquad_pkg::OPA_W'(x2_reg);
                mul_b = b2_reg;
            end
            biquad_pkg::OP_A1:
            begin
                mul_a = biquad_pkg::OPA_W'(y1_reg);
                mul_b = a1_reg;
            end
            biquad_pkg::OP_A2:
            begin
                mul_a = biquad_pkg::OPA_W'(y2_reg);
                mul_b = a2_reg;
            end
            biquad_pkg::OP_GAIN_LO:
            begin
                mul_a = $signed({1'b0, ff_reg[biquad_pkg::SPLIT_W-1:0]});
                mul_b = gain_reg;
            end
            biquad_pkg::OP_GAIN_HI:
            begin
                mul_a = ff_reg[biquad_pkg::FF_W-1:biquad_pkg::SPLIT_W];
                mul_b = gain_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        ff_next  = ff_reg;
        acc_next = acc_reg;
        if (in_take)
        begin
            ff_next  = '0;
            acc_next = ROUND_HALF;
        end
        else if (state_reg == biquad_pkg::ST_MAC && step_reg != biquad_pkg::OP_B0)
        begin
            case (prev_op) inside
                biquad_pkg::OP_B0, biquad_pkg::OP_B1, biquad_pkg::OP_B2:
                    ff_next = ff_reg + prod_reg;
                biquad_pkg::OP_A1, biquad_pkg::OP_A2:
                    acc_next = acc_reg - (prod_ext <<< COEF_FRAC_BITS);
                biquad_pkg::OP_GAIN_LO:
                    acc_next = acc_reg + prod_ext;
                biquad_pkg::OP_GAIN_HI:
                    acc_next = acc_reg + (prod_ext <<< biquad_pkg::SPLIT_W);
                default:
                    acc_next = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        y_wide = acc_reg >>> SHIFT;
        y_clip = 1'b1;
        if (y_wide > Y_MAX)
        begin
            y_sat = 16'sh7fff;
        end
        else if (y_wide < Y_MIN)
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat  = y_wide[biquad_pkg::DATA_W-1:0];
            y_clip = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            biquad_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = biquad_pkg::ST_MAC;
                    step_next  = biquad_pkg::OP_B0;
                end
            end
            biquad_pkg::ST_MAC:
            begin
                if (step_reg == biquad_pkg::OP_LAST)
                begin
                    state_next = biquad_pkg::ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + biquad_pkg::STEP_W'(1);
                end
            end
            biquad_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = biquad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = biquad_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= biquad_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            b0_reg        <= biquad_pkg::B0_RESET;
            b1_reg        <= '0;
            b2_reg        <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            gain_reg      <= biquad_pkg::GAIN_RESET;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    biquad_pkg::REG_B0:   b0_reg   <= cfg_data;
                    biquad_pkg::REG_B1:   b1_reg   <= cfg_data;
                    biquad_pkg::REG_B2:   b2_reg   <= cfg_data;
                    biquad_pkg::REG_A1:   a1_reg   <= cfg_data;
                    biquad_pkg::REG_A2:   a2_reg   <= cfg_data;
                    biquad_pkg::REG_GAIN: gain_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                x1_reg <= x_reg;
                x2_reg <= x1_reg;
                y1_reg <= y_sat;
                y2_reg <= y1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= sample;
        end
        prod_reg <= prod_next;
        ff_reg   <= ff_next;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            filtered_reg  <= y_sat;
            saturated_reg <= y_clip;
        end
    end

    property p_take_starts_mac;
        @(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == biquad_pkg::ST_MAC) && (step_reg == biquad_pkg::OP_B0);
    endproperty
    assert property (p_take_starts_mac)
        else $error("Accepted sample did not start the multiply sequence.");

    property p_load_presents_result;
        @(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && (state_reg == biquad_pkg::ST_IDLE);
    endproperty
    assert property (p_load_presents_result)
        else $error("Finished result was not presented on the output.");

    property p_history_matches_output;
        @(posedge clk) disable iff (!rst_n)
        out_load |=> (y1_reg == filtered);
    endproperty
    assert property (p_history_matches_output)
        else $error("Output history differs from the delivered result.");

endmodule
